FILE: sv/generational_slot_allocator_assert.svh
// Assertion macros shared by the slot allocator checker.
// Depends on a clk and rst signal in the scope of use.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/gsa_pkg.sv
// Shared types and codes for the generational slot allocator.
// No dependencies.
`timescale 1ns / 1ps

package gsa_pkg;

  localparam int GEN_W = 32;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_ALLOC   = 2'd0;
  localparam cmd_t CMD_RELEASE = 2'd1;
  localparam cmd_t CMD_RESOLVE = 2'd2;
  localparam cmd_t CMD_CLEAR   = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_STALE = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

FILE: sv/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/gsa_ctrl.sv
// Command sequencer for the slot allocator: accept, execute, report.
// Depends on gsa_pkg.
`timescale 1ns / 1ps

module gsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output gsa_pkg::ctl_t ctl
);

  import gsa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    ctl.load   = start && (state == S_IDLE);
    ctl.exec   = (state == S_EXEC);
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE:  state_next = ctl.load ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ctl.exec;
    end
  end

endmodule

FILE: sv/gsa_dp.sv
// Datapath of the slot allocator: slot table, free queue, counters, result word.
// Depends on gsa_pkg and gsa_ram.
`timescale 1ns / 1ps

module gsa_dp #(
  parameter int SLOTS = 64,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gsa_pkg::ctl_t               ctl,
  input  gsa_pkg::cmd_t               cmd,
  input  logic [IW-1:0]               slot_index,
  input  logic [gsa_pkg::GEN_W-1:0]   generation,
  output logic                        ok,
  output gsa_pkg::status_t            status,
  output logic [IW-1:0]               out_slot,
  output logic [gsa_pkg::GEN_W-1:0]   out_generation,
  output logic [CW-1:0]               active_count
);

  import gsa_pkg::*;

  localparam int SW = GEN_W + 1;
  localparam int QW = IW + GEN_W;

  cmd_t             cmd_q;
  logic [IW-1:0]    idx_q;
  logic [GEN_W-1:0] gen_q;

  logic [CW-1:0] slots_used, slots_used_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] live_count, live_count_next;

  logic             ok_next;
  status_t          status_next;
  logic [IW-1:0]    slot_next;
  logic [GEN_W-1:0] gen_out_next;

  logic          sw_en;
  logic [IW-1:0] sw_addr;
  logic [SW-1:0] sw_data;
  logic [SW-1:0] slot_rd;
  logic          fq_we;
  logic [QW-1:0] fq_wdata;
  logic [QW-1:0] fq_rd;

  logic             in_range;
  logic             cur_live;
  logic [GEN_W-1:0] cur_gen;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_bump;
  logic [IW-1:0]    head_inc;
  logic [IW-1:0]    tail_inc;

  gsa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
    .clk     (clk),
    .wr_en   (sw_en),
    .wr_addr (sw_addr),
    .wr_data (sw_data),
    .rd_en   (ctl.load),
    .rd_addr (slot_index),
    .rd_data (slot_rd)
  );

  gsa_ram #(.WIDTH(QW), .DEPTH(SLOTS)) u_free_ram (
    .clk     (clk),
    .wr_en   (fq_we),
    .wr_addr (tail),
    .wr_data (fq_wdata),
    .rd_en   (ctl.load),
    .rd_addr (head),
    .rd_data (fq_rd)
  );

  assign cur_live = slot_rd[SW-1];
  assign cur_gen  = slot_rd[GEN_W-1:0];
  assign gen_inc  = cur_gen + 1'b1;
  assign gen_bump = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign in_range = CW'(idx_q) < slots_used;
  assign head_inc = (head == IW'(SLOTS - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == IW'(SLOTS - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    slots_used_next = slots_used;
    head_next       = head;
    tail_next       = tail;
    free_count_next = free_count;
    live_count_next = live_count;
    ok_next         = 1'b0;
    status_next     = ST_OK;
    slot_next       = '0;
    gen_out_next    = '0;
    sw_en           = 1'b0;
    sw_addr         = idx_q;
    sw_data         = {1'b0, gen_bump};
    fq_we           = 1'b0;
    fq_wdata        = {idx_q, gen_bump};
    case (cmd_q)
      CMD_ALLOC: begin
        if (free_count != '0) begin
          slot_next       = fq_rd[QW-1:GEN_W];
          gen_out_next    = fq_rd[GEN_W-1:0];
          head_next       = head_inc;
          free_count_next = free_count - 1'b1;
          ok_next         = 1'b1;
        end else if (slots_used != CW'(SLOTS)) begin
          slot_next       = slots_used[IW-1:0];
          gen_out_next    = GEN_W'(1);
          slots_used_next = slots_used + 1'b1;
          ok_next         = 1'b1;
        end else begin
          status_next = ST_FULL;
        end
        if (ok_next) begin
          sw_en           = 1'b1;
          sw_addr         = slot_next;
          sw_data         = {1'b1, gen_out_next};
          live_count_next = live_count + 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else if (!cur_live) begin
          status_next = ST_STALE;
        end else begin
          sw_en           = 1'b1;
          fq_we           = 1'b1;
          tail_next       = tail_inc;
          free_count_next = free_count + 1'b1;
          if (live_count != '0) begin
            live_count_next = live_count - 1'b1;
          end
          ok_next = 1'b1;
        end
      end
      CMD_RESOLVE: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else if (gen_q == '0 || !cur_live || cur_gen != gen_q) begin
          status_next = ST_STALE;
        end else begin
          ok_next = 1'b1;
        end
      end
      CMD_CLEAR: begin
        slots_used_next = '0;
        head_next       = '0;
        tail_next       = '0;
        free_count_next = '0;
        live_count_next = '0;
        ok_next         = 1'b1;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      idx_q <= slot_index;
      gen_q <= generation;
    end
    if (ctl.exec) begin
      ok             <= ok_next;
      status         <= status_next;
      out_slot       <= slot_next;
      out_generation <= gen_out_next;
      active_count   <= live_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      head       <= '0;
      tail       <= '0;
      free_count <= '0;
      live_count <= '0;
    end else if (ctl.exec) begin
      slots_used <= slots_used_next;
      head       <= head_next;
      tail       <= tail_next;
      free_count <= free_count_next;
      live_count <= live_count_next;
    end
  end

endmodule

FILE: sv/generational_slot_allocator.sv
// Each command is accepted when start is high and busy is low, the slot table
// and free queue are read and written in the execute cycle that follows, and
// the result appears the cycle after that with done high for exactly one cycle.
// The receiver cannot stall, so results must be taken when done is high. A new
// command may be accepted in the same cycle that done is shown. Clear is a
// single command: slots never handed out since the last clear are out of range
// and are handed out fresh with generation 1, so no sweep of the tables is
// needed. Freed slots are reused oldest first.
// Depends on gsa_pkg, gsa_ctrl, gsa_dp.
`timescale 1ns / 1ps

module generational_slot_allocator #(
  parameter int SLOTS = 64,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gsa_pkg::cmd_t               cmd,
  input  logic [IW-1:0]               slot_index,
  input  logic [gsa_pkg::GEN_W-1:0]   generation,
  output logic                        done,
  output logic                        ok,
  output gsa_pkg::status_t            status,
  output logic [IW-1:0]               out_slot,
  output logic [gsa_pkg::GEN_W-1:0]   out_generation,
  output logic [CW-1:0]               active_count
);

  import gsa_pkg::*;

  ctl_t ctl;

  gsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  gsa_dp #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .cmd            (cmd),
    .slot_index     (slot_index),
    .generation     (generation),
    .ok             (ok),
    .status         (status),
    .out_slot       (out_slot),
    .out_generation (out_generation),
    .active_count   (active_count)
  );

endmodule

FILE: sv/gsa_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
// Depends on gsa_pkg and generational_slot_allocator_assert.svh.
`timescale 1ns / 1ps
`include "generational_slot_allocator_assert.svh"

module gsa_checker #(
  parameter int SLOTS = 64,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  ok,
  input gsa_pkg::status_t      status,
  input logic [CW-1:0]         active_count
);

  import gsa_pkg::*;

  `GSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted word did not go busy")
  `GSA_ASSERT_NEXT(a_busy_done, busy, done && !busy, "result word missing after execute")
  `GSA_ASSERT_NOW(a_ok_status, done, ok == (status == ST_OK), "ok and status disagree")
  `GSA_ASSERT_NOW(a_count_max, done, active_count <= CW'(SLOTS), "active count above pool size")

endmodule

bind generational_slot_allocator gsa_checker #(.SLOTS(SLOTS)) u_gsa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .ok           (ok),
  .status       (status),
  .active_count (active_count)
);
